@@ rtl/mvt_pkg.sv @@
// Shared types and constants for the matrix-vector transform core.
`timescale 1ns / 1ps

package mvt_pkg;

  localparam int DATA_W            = 32;
  localparam int PROD_W            = 2 * DATA_W;
  localparam int MAX_DIM           = 4;
  localparam int NUM_ELEMS         = MAX_DIM * MAX_DIM;
  localparam int IDX_W             = $clog2(NUM_ELEMS);
  localparam int DIM_DEFAULT       = 4;
  localparam int FRAC_BITS_DEFAULT = 16;

  typedef enum logic [0:0] {
    OP_LOAD      = 1'b0,
    OP_TRANSFORM = 1'b1
  } op_t;

  // Stage load enables handed from the pipeline control to every lane.
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } lane_ctrl_t;

endpackage

@@ rtl/matrix_vector_transform_core.sv @@
// Top level of the 4x4 fixed-point matrix-vector transform core.
`timescale 1ns / 1ps

// The core holds a 4x4 matrix of signed fixed-point elements (Q16.16 with the
// default FRAC_BITS), stored column-major (index = row + 4*column) and reset
// to identity. An input transfer with opcode OP_LOAD writes one element and
// produces no output. A transfer with OP_TRANSFORM produces one output: each
// component is the full-precision dot product of a matrix row with
// (vec_x, vec_y, vec_z, vec_w), floor-shifted right by FRAC_BITS and
// saturated to 32 bits; overflow is set if any component clamped. Components
// at or above DIM read zero. Throughput is one transfer per clock while the
// output is not stalled, loads and transforms mixed freely; a load takes
// effect for a transform accepted in the very next cycle. One row lane per
// component runs DIM multipliers, a two-level adder tree and the clamp over
// three registered stages, then the merge stage registers the result. The
// output register decouples the sides, so input transfers keep flowing while
// a finished result waits, until all stages hold data.

module matrix_vector_transform_core #(
  parameter int DIM       = mvt_pkg::DIM_DEFAULT,
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [0:0]                        opcode,
  input  logic [mvt_pkg::IDX_W-1:0]         element_index,
  input  logic signed [mvt_pkg::DATA_W-1:0] element_value,
  input  logic signed [mvt_pkg::DATA_W-1:0] vec_x,
  input  logic signed [mvt_pkg::DATA_W-1:0] vec_y,
  input  logic signed [mvt_pkg::DATA_W-1:0] vec_z,
  input  logic signed [mvt_pkg::DATA_W-1:0] vec_w,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mvt_pkg::DATA_W-1:0] out_x,
  output logic signed [mvt_pkg::DATA_W-1:0] out_y,
  output logic signed [mvt_pkg::DATA_W-1:0] out_z,
  output logic signed [mvt_pkg::DATA_W-1:0] out_w,
  output logic                              overflow
);

  // Matrix register file; every lane reads its own fixed row of entries.
  logic signed [mvt_pkg::DATA_W-1:0] matrix [mvt_pkg::NUM_ELEMS];

  logic signed [mvt_pkg::DATA_W-1:0] vec      [mvt_pkg::MAX_DIM];
  logic signed [mvt_pkg::DATA_W-1:0] lane_res [mvt_pkg::MAX_DIM];
  logic        [mvt_pkg::MAX_DIM-1:0] lane_ovf;

  // Pipeline occupancy: s1 products, s2 partial sums, s3 clamped results.
  logic v1, v2, v3;
  logic ready1, ready2, ready3;
  logic merge_ready;
  logic in_xfer;
  logic is_load;
  mvt_pkg::lane_ctrl_t ctrl;

  assign is_load = (opcode == mvt_pkg::OP_LOAD);
  assign in_xfer = in_valid && in_ready;

  // A stage takes new data when empty or when its contents move on.
  assign ready3   = !v3 || merge_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  assign ctrl.s1_en = ready1;
  assign ctrl.s2_en = ready2;
  assign ctrl.s3_en = ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= in_valid && !is_load;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  // Load path: written at the transfer edge, identity after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < mvt_pkg::MAX_DIM; r++) begin
        for (int c = 0; c < mvt_pkg::MAX_DIM; c++) begin
          if (r == c) begin
            matrix[r + mvt_pkg::MAX_DIM * c] <= mvt_pkg::DATA_W'(1) << FRAC_BITS;
          end else begin
            matrix[r + mvt_pkg::MAX_DIM * c] <= '0;
          end
        end
      end
    end else if (in_xfer && is_load) begin
      matrix[element_index] <= element_value;
    end
  end

  assign vec[0] = vec_x;
  assign vec[1] = vec_y;
  assign vec[2] = vec_z;
  assign vec[3] = vec_w;

  // One lane per used row; rows at or above DIM give zero, no overflow.
  for (genvar r = 0; r < mvt_pkg::MAX_DIM; r++) begin : g_row
    if (r < DIM) begin : g_lane
      logic signed [mvt_pkg::DATA_W-1:0] row_elems [mvt_pkg::MAX_DIM];

      for (genvar c = 0; c < mvt_pkg::MAX_DIM; c++) begin : g_tap
        assign row_elems[c] = matrix[r + mvt_pkg::MAX_DIM * c];
      end

      mvt_lane #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
      ) u_lane (
        .clk       (clk),
        .ctrl      (ctrl),
        .row_elems (row_elems),
        .vec       (vec),
        .result    (lane_res[r]),
        .ovf       (lane_ovf[r])
      );
    end else begin : g_unused
      assign lane_res[r] = '0;
      assign lane_ovf[r] = 1'b0;
    end
  end

  mvt_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (merge_ready),
    .lane_res  (lane_res),
    .lane_ovf  (lane_ovf),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w),
    .overflow  (overflow)
  );

  // A load never enters the pipeline.
  a_load_no_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer && is_load |=> !v1)
    else $error("load transfer entered the pipeline");

  // A transform always enters the pipeline.
  a_xform_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !is_load |=> v1)
    else $error("transform transfer lost at pipeline entry");

  // A load lands in the addressed matrix entry.
  a_load_write: assert property (@(posedge clk) disable iff (rst)
    in_xfer && is_load |=> matrix[$past(element_index)] == $past(element_value))
    else $error("matrix element not written by load");

  // With the consumer ready the whole pipeline moves, so input is never held.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output ready");

endmodule

@@ rtl/mvt_lane.sv @@
// One row lane: column products, adder tree, fraction shift and saturation.
`timescale 1ns / 1ps

module mvt_lane #(
  parameter int DIM       = mvt_pkg::DIM_DEFAULT,
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                              clk,
  input  mvt_pkg::lane_ctrl_t               ctrl,
  input  logic signed [mvt_pkg::DATA_W-1:0] row_elems [mvt_pkg::MAX_DIM],
  input  logic signed [mvt_pkg::DATA_W-1:0] vec       [mvt_pkg::MAX_DIM],
  output logic signed [mvt_pkg::DATA_W-1:0] result,
  output logic                              ovf
);

  localparam int PAIR_W = mvt_pkg::PROD_W + 1;
  localparam int SUM_W  = mvt_pkg::PROD_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

  logic signed [mvt_pkg::PROD_W-1:0] prod [mvt_pkg::MAX_DIM];
  logic signed [PAIR_W-1:0]          pair [2];
  logic signed [SUM_W-1:0]           total;
  logic signed [SUM_W-1:0]           shifted;

  // stage 1: one multiplier per used column, unused columns read as zero
  for (genvar c = 0; c < mvt_pkg::MAX_DIM; c++) begin : g_col
    always_ff @(posedge clk) begin
      if (ctrl.s1_en) begin
        if (c < DIM) begin
          prod[c] <= row_elems[c] * vec[c];
        end else begin
          prod[c] <= '0;
        end
      end
    end
  end

  // stage 2: first level of the adder tree
  always_ff @(posedge clk) begin
    if (ctrl.s2_en) begin
      pair[0] <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair[1] <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    end
  end

  // stage 3: final add, floor shift, clamp
  always_comb begin
    total   = SUM_W'(pair[0]) + SUM_W'(pair[1]);
    shifted = total >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (ctrl.s3_en) begin
      if (shifted > SAT_HI) begin
        result <= SAT_HI[mvt_pkg::DATA_W-1:0];
        ovf    <= 1'b1;
      end else if (shifted < SAT_LO) begin
        result <= SAT_LO[mvt_pkg::DATA_W-1:0];
        ovf    <= 1'b1;
      end else begin
        result <= shifted[mvt_pkg::DATA_W-1:0];
        ovf    <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/mvt_merge.sv @@
// Merge stage: collects the lane results into the output register.
`timescale 1ns / 1ps

module mvt_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [mvt_pkg::DATA_W-1:0] lane_res [mvt_pkg::MAX_DIM],
  input  logic        [mvt_pkg::MAX_DIM-1:0] lane_ovf,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mvt_pkg::DATA_W-1:0] out_x,
  output logic signed [mvt_pkg::DATA_W-1:0] out_y,
  output logic signed [mvt_pkg::DATA_W-1:0] out_z,
  output logic signed [mvt_pkg::DATA_W-1:0] out_w,
  output logic                              overflow
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_x    <= lane_res[0];
      out_y    <= lane_res[1];
      out_z    <= lane_res[2];
      out_w    <= lane_res[3];
      overflow <= |lane_ovf;
    end
  end

endmodule

@@ tb/matrix_vector_transform_core_tb.sv @@
// Self-checking testbench for the fixed-point matrix-vector transform core.
`timescale 1ns / 1ps

module matrix_vector_transform_core_tb;
  import mvt_pkg::*;

  localparam int XF_DIM      = DIM_DEFAULT;
  localparam int XF_FRAC     = FRAC_BITS_DEFAULT;
  localparam int RAND_ITEMS  = 1504;
  localparam int RAND_PHASES = 8;
  localparam int TAIL_CYCLES = 16;
  localparam int LIMIT_NS    = 12 * 400000;

  localparam logic signed [67:0] Q_MAX = 68'sh7FFF_FFFF;
  localparam logic signed [67:0] Q_MIN = -68'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] w;
    logic                     ovf;
  } xf_result_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] w;
    logic              typed;
    xf_result_t        want;
  } stim_row_t;

  localparam xf_result_t NO_WANT = '0;
  localparam int DIR_ROWS = 24;

  // Directed table. Rows with typed set carry a result read straight off the
  // matrix contents (identity after reset, or saturation); the rest go
  // through the predictor.
  stim_row_t dir_table [DIR_ROWS] = '{
    // identity after reset passes the vector through
    '{OP_TRANSFORM, 4'd0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h7FFF_0000,
      1'b1, '{32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h7FFF_0000, 1'b0}},
    // extremes through identity, element fields ignored
    '{OP_TRANSFORM, 4'd15, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
      32'hFFFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0}},
    '{OP_TRANSFORM, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0}},
    // loads, the first with vector fields set to noise
    '{OP_LOAD, 4'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b0, NO_WANT},
    '{OP_LOAD, 4'd4, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WANT},
    // row 0 saturates high, the rest stay exact
    '{OP_TRANSFORM, 4'd0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0,
      1'b1, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1}},
    // row 0 saturates low
    '{OP_TRANSFORM, 4'd0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0,
      1'b1, '{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b1}},
    '{OP_LOAD, 4'd0, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WANT},
    '{OP_LOAD, 4'd4, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WANT},
    '{OP_LOAD, 4'd8, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WANT},
    '{OP_LOAD, 4'd12, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WANT},
    // four largest products: exact sum is 2^64, past any 64-bit accumulator
    '{OP_TRANSFORM, 4'd0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
      1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1}},
    // smallest element times a negative lsb: floor, not round toward zero
    '{OP_LOAD, 4'd5, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WANT},
    '{OP_TRANSFORM, 4'd3, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, NO_WANT},
    '{OP_LOAD, 4'd15, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WANT},
    '{OP_LOAD, 4'd10, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WANT},
    '{OP_TRANSFORM, 4'd0, 32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
      1'b0, NO_WANT},
    '{OP_LOAD, 4'd3, 32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WANT},
    '{OP_LOAD, 4'd6, 32'h8000_0001, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WANT},
    '{OP_LOAD, 4'd9, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WANT},
    '{OP_LOAD, 4'd14, 32'h0001_8000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WANT},
    '{OP_TRANSFORM, 4'd0, 32'h0, 32'hFFFF_8000, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
      1'b0, NO_WANT},
    '{OP_TRANSFORM, 4'd7, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
      1'b0, NO_WANT},
    '{OP_TRANSFORM, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, NO_WANT}
  };

  int phase_idle  [4] = '{0, 59, 0, 23};
  int phase_stall [4] = '{0, 0, 59, 23};

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [0:0]        opcode        = 1'b0;
  logic [IDX_W-1:0]  element_index = '0;
  logic [DATA_W-1:0] element_value = '0;
  logic [DATA_W-1:0] vec_x         = '0;
  logic [DATA_W-1:0] vec_y         = '0;
  logic [DATA_W-1:0] vec_z         = '0;
  logic [DATA_W-1:0] vec_w         = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [DATA_W-1:0] out_x;
  logic [DATA_W-1:0] out_y;
  logic [DATA_W-1:0] out_z;
  logic [DATA_W-1:0] out_w;
  logic              overflow;

  logic signed [DATA_W-1:0] coeff_mem [NUM_ELEMS];
  xf_result_t               pending_results [$];
  int                       err_count      = 0;
  int                       send_idle_pct  = 0;
  int                       sink_stall_pct = 0;

  matrix_vector_transform_core #(
    .DIM       (XF_DIM),
    .FRAC_BITS (XF_FRAC)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .element_index (element_index),
    .element_value (element_value),
    .vec_x         (vec_x),
    .vec_y         (vec_y),
    .vec_z         (vec_z),
    .vec_w         (vec_w),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w         (out_w),
    .overflow      (overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Exact dot product per row, floor shift, clamp to 32 bits.
  function automatic xf_result_t transform_vector(input logic [DATA_W-1:0] x, y, z, w);
    logic signed [DATA_W-1:0] v [4];
    logic signed [67:0]       acc;
    logic signed [DATA_W-1:0] comp [4];
    xf_result_t               res;
    logic                     ovf;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    v[3] = w;
    ovf = 1'b0;
    for (int r = 0; r < 4; r++) begin
      comp[r] = '0;
      if (r < XF_DIM) begin
        acc = '0;
        for (int c = 0; c < XF_DIM; c++)
          acc = acc + coeff_mem[r + 4 * c] * v[c];
        acc = acc >>> XF_FRAC;
        if (acc > Q_MAX) begin
          acc = Q_MAX;
          ovf = 1'b1;
        end else if (acc < Q_MIN) begin
          acc = Q_MIN;
          ovf = 1'b1;
        end
        comp[r] = acc[DATA_W-1:0];
      end
    end
    res = '{comp[0], comp[1], comp[2], comp[3], ovf};
    return res;
  endfunction

  // Mostly moderate Q16.16 values so results stay in range, with full-range
  // and corner values mixed in.
  function automatic logic [DATA_W-1:0] rand_fixed();
    logic [DATA_W-1:0] v;
    case ($urandom_range(9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(6))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0;
          3: v = 32'h1;
          4: v = 32'hFFFF_FFFF;
          5: v = 32'h0001_0000;
          default: v = 32'hFFFF_0000;
        endcase
      end
      default: v = int'($urandom_range(20'hF_FFFF)) - 524288;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got, want);
    $display("%0t ERROR %s: got %h expected %h", $time, what, got, want);
    err_count++;
  endtask

  // One input transfer with a random idle gap ahead of it. On acceptance the
  // matrix copy is updated, or the expected result queued.
  task automatic send_item(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val, x, y, z, w,
                           input logic typed, input xf_result_t want);
    int gap;
    gap = 0;
    while (gap < 50 && $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    element_index <= idx;
    element_value <= val;
    vec_x         <= x;
    vec_y         <= y;
    vec_z         <= z;
    vec_w         <= w;
    @(posedge clk);
    while (in_ready !== 1'b1)
      @(posedge clk);
    if (op == OP_LOAD)
      coeff_mem[idx] = val;
    else
      pending_results.push_back(typed ? want : transform_vector(x, y, z, w));
  endtask

  // Sender holds off until every queued result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk) begin : check_results
    xf_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, out_x", out_x, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
        if (out_w !== want.w) report_mismatch("out_w", out_w, want.w);
        if (overflow !== want.ovf) report_mismatch("overflow", 32'(overflow), 32'(want.ovf));
      end
    end
  end

  initial begin
    stim_row_t row;
    op_t       op;
    for (int i = 0; i < NUM_ELEMS; i++)
      coeff_mem[i] = (i % 5 == 0) ? (32'sd1 <<< XF_FRAC) : 32'sd0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 23;
    sink_stall_pct = 23;
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_table[i];
      send_item(row.op, row.idx, row.val, row.x, row.y, row.z, row.w, row.typed, row.want);
    end
    drain_results();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      send_idle_pct  = phase_idle[ph % 4];
      sink_stall_pct = phase_stall[ph % 4];
      for (int n = 0; n < RAND_ITEMS / RAND_PHASES; n++) begin
        op = ($urandom_range(99) < 35) ? OP_LOAD : OP_TRANSFORM;
        send_item(op, IDX_W'($urandom_range(NUM_ELEMS - 1)), rand_fixed(), rand_fixed(),
                  rand_fixed(), rand_fixed(), rand_fixed(), 1'b0, NO_WANT);
      end
      drain_results();
    end

    // watch for stray results after the last one expected
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("matrix_vector_transform_core_tb passed");
    else
      $display("matrix_vector_transform_core_tb failed");
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("matrix_vector_transform_core_tb failed");
    $finish;
  end

endmodule
